FILE: src/sapq_pkg.sv
// Shared constants and types for the sorted-array priority queue.
`timescale 1ns / 1ps
`default_nettype none
package sapq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int STAT_W  = 2;
    localparam int HELD_W  = 5;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Datapath actions chosen by the controller
    localparam logic [1:0] ACT_ENQ    = 2'd0;
    localparam logic [1:0] ACT_DEQ    = 2'd1;
    localparam logic [1:0] ACT_REJ_FULL  = 2'd2;
    localparam logic [1:0] ACT_REJ_EMPTY = 2'd3;

    typedef struct packed {
        logic       load;
        logic [1:0] action;
    } sapq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sapq_stat_t;

endpackage
`default_nettype wire

FILE: src/sapq_datapath.sv
// Slot register array with parallel compare-and-shift, fill count and result registers.
`timescale 1ns / 1ps
`default_nettype none
module sapq_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire sapq_pkg::sapq_cmd_t            cmd,
    output sapq_pkg::sapq_stat_t                stat,
    input  wire logic signed [31:0]             value_in,
    input  wire logic [15:0]                    prio_in,
    output logic [1:0]                          status_out,
    output logic signed [31:0]                  value_out,
    output logic [4:0]                          entries_held
);
    import sapq_pkg::*;

    logic [VALUE_W-1:0] slot_value_reg [DEPTH];
    logic [VALUE_W-1:0] slot_value_next [DEPTH];
    logic [PRIO_W-1:0]  slot_prio_reg  [DEPTH];
    logic [PRIO_W-1:0]  slot_prio_next [DEPTH];
    logic [CNT_W-1:0]   fill_count_reg, fill_count_next;
    logic [DEPTH-1:0]   stay;

    logic [STAT_W-1:0]  status_reg, status_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W+HELD_W-1:0] held_ext;

    always_comb begin
        stat.full  = (fill_count_reg == CNT_W'(DEPTH));
        stat.empty = (fill_count_reg == '0);
    end

    // Stored entries that outrank or tie the new priority form a prefix; they stay put
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            stay[i] = (CNT_W'(i) < fill_count_reg) && (slot_prio_reg[i] >= prio_in);
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            slot_value_next[i] = slot_value_reg[i];
            slot_prio_next[i]  = slot_prio_reg[i];
        end
        fill_count_next = fill_count_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        if (cmd.load) begin
            value_next = '0;
            unique case (cmd.action)
                ACT_ENQ: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!stay[i]) begin
                            if (i == 0) begin
                                slot_value_next[i] = value_in;
                                slot_prio_next[i]  = prio_in;
                            end else if (stay[(i == 0) ? 0 : i - 1]) begin
                                slot_value_next[i] = value_in;
                                slot_prio_next[i]  = prio_in;
                            end else begin
                                slot_value_next[i] = slot_value_reg[(i == 0) ? 0 : i - 1];
                                slot_prio_next[i]  = slot_prio_reg[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                    fill_count_next = fill_count_reg + 1'b1;
                    status_next     = ST_OK;
                end
                ACT_DEQ: begin
                    // advance every entry one place towards the front
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        slot_value_next[i] = slot_value_reg[i + 1];
                        slot_prio_next[i]  = slot_prio_reg[i + 1];
                    end
                    value_next      = slot_value_reg[0];
                    fill_count_next = fill_count_reg - 1'b1;
                    status_next     = ST_OK;
                end
                ACT_REJ_FULL:  status_next = ST_FULL;
                ACT_REJ_EMPTY: status_next = ST_EMPTY;
                default:       status_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            slot_value_reg[i] <= slot_value_next[i];
            slot_prio_reg[i]  <= slot_prio_next[i];
        end
        status_reg <= status_next;
        value_reg  <= value_next;
        if (!aresetn) begin
            fill_count_reg <= '0;
        end else begin
            fill_count_reg <= fill_count_next;
        end
    end

    assign held_ext     = {{HELD_W{1'b0}}, fill_count_reg};
    assign status_out   = status_reg;
    assign value_out    = value_reg;
    assign entries_held = held_ext[HELD_W-1:0];

endmodule
`default_nettype wire

FILE: src/sapq_ctrl.sv
// Handshake controller: chooses the datapath action and tracks the held result.
`timescale 1ns / 1ps
`default_nettype none
module sapq_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 opcode,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sapq_pkg::sapq_cmd_t       cmd,
    input  wire sapq_pkg::sapq_stat_t stat
);
    import sapq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic state_reg, state_next;
    logic accept;

    // take a new item whenever the result slot is free or being drained
    assign s_ready = (state_reg == S_IDLE) || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = (state_reg == S_HOLD);

    always_comb begin
        cmd.load = accept;
        if (opcode == OP_ENQ) begin
            cmd.action = stat.full ? ACT_REJ_FULL : ACT_ENQ;
        end else begin
            cmd.action = stat.empty ? ACT_REJ_EMPTY : ACT_DEQ;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_HOLD;
            S_HOLD:  if (m_ready && !accept) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_never_full_and_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.full && stat.empty))
        else $error("queue reports full and empty at once");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted item produced no result");

    a_no_enq_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && cmd.action == ACT_ENQ) |-> !stat.full)
        else $error("enqueue issued to a full queue");

    a_no_deq_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && cmd.action == ACT_DEQ) |-> !stat.empty)
        else $error("dequeue issued to an empty queue");

    a_drain_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !s_valid) |=> !m_valid)
        else $error("drained result still shown");

endmodule
`default_nettype wire

FILE: src/sorted_array_priority_queue.sv
// Top level of the sorted-array priority queue.
// Bounded priority queue of DEPTH (16) entries held in descending priority order;
// equal priorities leave in arrival order. One item is taken per clock cycle while
// m_ready is high: every slot compares its priority with the new one and shifts in
// the same cycle, and the result is registered, so it appears the cycle after
// acceptance and a new item is accepted in the cycle its predecessor's result is
// taken. The slot compare-and-shift sets this figure. An enqueue to a full queue
// returns status 1, a dequeue from an empty queue status 2, value_out zero.
`timescale 1ns / 1ps
`default_nettype none
module sorted_array_priority_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_opcode,
    input  wire logic signed [31:0] s_value_in,
    input  wire logic [15:0]        s_prio_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_value_out,
    output logic [4:0]              m_entries_held
);
    import sapq_pkg::*;

    sapq_cmd_t  cmd;
    sapq_stat_t stat;

    sapq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_opcode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    sapq_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .value_in     (s_value_in),
        .prio_in      (s_prio_in),
        .status_out   (m_status),
        .value_out    (m_value_out),
        .entries_held (m_entries_held)
    );

endmodule
`default_nettype wire
